/* src/slug_pkg.sv */
package slug_pkg;

   localparam int unsigned SLUG_TABLE_DEPTH = 32;
   localparam int unsigned SLUG_WARMUP      = 8;
   localparam logic [30:0] SLUG_MOD         = 31'h7FFF_FFFF;
   localparam logic [14:0] SLUG_MULT        = 15'd16807;
   localparam logic [30:0] SLUG_SAMPLE_MAX  = 31'd2147483389;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SEED = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_STEP = 5'b01000,
      ST_DONE = 5'b10000
   } slug_state_type;

   // reduce a 46-bit product modulo 2^31-1: add the high part to the low part,
   // then subtract the modulus once if the sum reaches it
   function automatic logic [30:0] slug_fold(input logic [45:0] prod);
      logic [31:0] sum;
      logic [31:0] red;
      sum = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
      red = sum - {1'b0, SLUG_MOD};
      if (sum >= {1'b0, SLUG_MOD}) begin
         return red[30:0];
      end
      return sum[30:0];
   endfunction

endpackage

/* src/shuffled_lcg_uniform_generator.sv */
// Shuffled uniform generator: a minimal-standard multiplicative congruential
// generator (x * 16807 mod 2^31-1) behind a shuffle table of TABLE_DEPTH entries.
// req channel: one transaction per draw; req_reseed = 1 reseeds from the seed
// register first. rsp channel: one transaction per request, rsp_sample being the
// draw as a numerator over 2147483647, saturated at 2147483389.
// csr port: csr_we writes csr_wdata into the seed register (zero acts as one).
// One 31x15 multiplier and a fold adder form the generator step; the table pick
// compares the last draw against the TABLE_DEPTH - 1 constant bucket bounds.
// A plain draw, once accepted, runs the pick, the multiply and fold phases of
// the step, and the output load before rsp_valid. A reseed, or the first
// request after reset, first runs the warm-up steps and the table fill.
// One request is in work at a time; req_ready is high only while idle, so the
// block takes no new request until the last one's result is in the output
// register.
// A result waits in the output register while rsp_ready is low; the block
// accepts the next request during that wait but finishes it only once the
// waiting result has been taken.
// Reset sets the seed to 1 and marks the generator unseeded, so the first
// request seeds the table whatever its reseed bit.
module shuffled_lcg_uniform_generator
   import slug_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = SLUG_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_reseed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_sample,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(SLUG_WARMUP + TABLE_DEPTH);
   localparam logic [31:0] DIVISOR = 32'(1 + (32'h7FFF_FFFE / TABLE_DEPTH));
   localparam logic [CW-1:0] SEED_STEPS_LAST = CW'(SLUG_WARMUP + TABLE_DEPTH - 1);
   localparam logic [IW-1:0] PICK_MAX = IW'(TABLE_DEPTH - 1);

   slug_state_type state_ff, state_in;
   logic [30:0]    seed_ff, seed_in;
   logic [30:0]    gen_ff, gen_in;
   logic [30:0]    last_ff, last_in;
   logic [45:0]    prod_ff, prod_in;
   logic           phase_ff, phase_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [IW-1:0]  quot_ff, quot_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [30:0]    rsp_sample_ff, rsp_sample_in;
   logic [30:0]    rd_ff;

   logic [30:0]    mem [TABLE_DEPTH];
   logic           mem_we;
   logic [IW-1:0]  mem_waddr;
   logic [IW-1:0]  pick;
   logic [IW-1:0]  bucket;
   logic [30:0]    folded;
   logic [30:0]    seed_start;
   logic           req_take;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   assign folded     = slug_fold(prod_ff);
   assign seed_start = ((seed_ff == 31'd0) || (seed_ff == SLUG_MOD)) ? 31'd1 : seed_ff;
   assign pick       = (quot_ff > PICK_MAX) ? PICK_MAX : quot_ff;

   // bucket of the last draw: count the constant bounds it reaches
   always_comb begin
      bucket = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if ({1'b0, last_ff} >= (32'(k) * DIVISOR)) begin
            bucket = IW'(k);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      seed_in       = csr_we ? csr_wdata : seed_ff;
      gen_in        = gen_ff;
      last_in       = last_ff;
      prod_in       = 46'(gen_ff) * 46'(SLUG_MULT);
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      quot_in       = quot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      mem_we        = 1'b0;
      mem_waddr     = pick;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_reseed || (last_ff == 31'd0)) begin
                  gen_in   = seed_start;
                  cnt_in   = SEED_STEPS_LAST;
                  phase_in = 1'b0;
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_SEED: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               gen_in = folded;
               // fill the table from the top entry down during the last steps
               if (cnt_ff < CW'(TABLE_DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[IW-1:0];
               end
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  last_in  = folded;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            quot_in  = bucket;
            phase_in = 1'b0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // multiply phase reads the picked entry, fold phase swaps it
            phase_in = ~phase_ff;
            if (phase_ff) begin
               gen_in   = folded;
               mem_we   = 1'b1;
               last_in  = rd_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = (last_ff > SLUG_SAMPLE_MAX) ? SLUG_SAMPLE_MAX : last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= 31'd1;
         gen_ff       <= '0;
         last_ff      <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
         last_ff      <= last_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      quot_ff       <= quot_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= folded;
      end
      rd_ff <= mem[pick];
   end

   a_reseed_seeds: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_reseed) |=> (state_ff == ST_SEED))
      else $error("reseed request did not start seeding");

   a_div_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (last_ff != 31'd0))
      else $error("draw started on an unseeded generator");

   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (32'(quot_ff) < TABLE_DEPTH))
      else $error("table pick out of range");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready) |=>
      ((state_ff == ST_DONE) && $stable(rsp_sample_ff)))
      else $error("pending result overwritten");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_sample_ff != 31'd0) && (rsp_sample_ff <= SLUG_SAMPLE_MAX)))
      else $error("sample out of range");

endmodule

/* test/tb_shuffled_lcg_uniform_generator.sv */
module tb_shuffled_lcg_uniform_generator;
   import slug_pkg::*;

   localparam int unsigned DEPTH        = SLUG_TABLE_DEPTH;
   localparam int unsigned CYCLE_LIMIT  = 800000;
   localparam int unsigned RSP_STALL    = 400;
   localparam int unsigned PHASES       = 10;
   localparam int unsigned PHASE_ITEMS  = 120;
   localparam int unsigned SETTLE       = 100;

   // Minimal-standard generator with shuffle table, tracked per accepted request.
   class uniform_draw_book;
      bit [30:0] seed_reg;
      bit [30:0] gen_value;
      bit [30:0] last_draw;
      bit [30:0] shuffle [DEPTH];
      bit [30:0] expected_samples [$];
      int unsigned errors;

      function new();
         seed_reg  = 31'd1;
         gen_value = '0;
         last_draw = '0;
         errors    = 0;
         foreach (shuffle[i]) shuffle[i] = '0;
      endfunction

      function void set_seed(input bit [30:0] value);
         seed_reg = value;
      endfunction

      function bit [30:0] mcg_step(input bit [30:0] x);
         longint unsigned prod;
         prod = longint'(x) * 64'd16807;
         return 31'(prod % 64'd2147483647);
      endfunction

      function void reseed_table();
         bit [30:0] x;
         x = seed_reg;
         if (x == 31'd0 || x == SLUG_MOD) x = 31'd1;
         repeat (SLUG_WARMUP) x = mcg_step(x);
         for (int i = DEPTH - 1; i >= 0; i--) begin
            x = mcg_step(x);
            shuffle[i] = x;
         end
         gen_value = x;
         last_draw = shuffle[0];
      endfunction

      function void note_request(input bit reseed);
         int unsigned divisor;
         int unsigned pick;
         bit [30:0] sample;
         divisor = 1 + (32'd2147483646 / DEPTH);
         // an unseeded generator seeds on its first draw whatever the reseed bit
         if (reseed || last_draw == 31'd0) reseed_table();
         gen_value = mcg_step(gen_value);
         pick = last_draw / divisor;
         if (pick > DEPTH - 1) pick = DEPTH - 1;
         last_draw = shuffle[pick];
         shuffle[pick] = gen_value;
         sample = (last_draw > SLUG_SAMPLE_MAX) ? SLUG_SAMPLE_MAX : last_draw;
         expected_samples.push_back(sample);
      endfunction

      function void check_sample(input bit [30:0] actual);
         bit [30:0] want;
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected rsp transaction, sample %0d", $time, actual);
            errors++;
         end else begin
            want = expected_samples.pop_front();
            if (want != actual) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_reseed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [30:0] rsp_sample;
   logic        csr_we;
   logic [30:0] csr_wdata;

   uniform_draw_book book;
   bit          req_calm;
   bit          rsp_calm;
   bit          rsp_stall_armed;
   int unsigned cycle_count = 0;

   shuffled_lcg_uniform_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_reseed (req_reseed),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("shuffled_lcg_uniform_generator verification failed");
         $finish;
      end
   end

   task automatic send_request(input bit reseed);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_reseed <= reseed;
      do @(posedge clock); while (!req_ready);
      book.note_request(reseed);
   endtask

   task automatic write_seed(input bit [30:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      book.set_seed(value);
   endtask

   // drop valid, then wait out every outstanding draw plus the pipeline tail
   task automatic drain(input int unsigned tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   initial begin : rsp_side
      int unsigned gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_stall_armed) begin
            gap = RSP_STALL;
            rsp_stall_armed = 1'b0;
         end else begin
            gap = rsp_calm ? 0 : $urandom_range(0, 12);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         book.check_sample(rsp_sample);
      end
   end

   initial begin : main_seq
      bit [30:0] seed;
      book            = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_reseed      = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_calm        = 1'b0;
      rsp_calm        = 1'b0;
      rsp_stall_armed = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first draw with reseed low still seeds from the reset seed
      send_request(1'b0);
      repeat (3) send_request(1'b0);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
      drain(12);
      write_seed(31'd0);
      send_request(1'b1);
      send_request(1'b0);
      drain(12);
      write_seed(SLUG_MOD);
      send_request(1'b1);
      send_request(1'b0);
      drain(12);
      write_seed(31'd2147483646);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      drain(12);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: seed = 31'd1;
            1: seed = 31'd0;
            2: seed = 31'd2147483646;
            3: seed = SLUG_MOD;
            default: seed = 31'($urandom());
         endcase
         write_seed(seed);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         // hold the receiver off while requests keep coming so the block backs up
         if (phase == 2 || phase == 7) rsp_stall_armed = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request($urandom_range(0, 15) == 0);
         end
         drain(12);
      end

      drain(SETTLE);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("shuffled_lcg_uniform_generator verification clean");
      end else begin
         $display("shuffled_lcg_uniform_generator verification failed");
      end
      $finish;
   end

endmodule
